// ===== design/gpt_pkg.sv =====
// Shared types, constants and the arctangent table builder for the geofence trigger.
// Used by the controller, the datapath, the CORDIC unit and the top level.
package gpt_pkg;

    localparam int DATA_W     = 64;
    localparam int LAT_W      = 31;
    localparam int LON_W      = 32;
    localparam int RADIUS_W   = 16;
    localparam int UNITS_W    = 34;
    localparam int MAG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int ATAN_LEN   = 60;
    localparam int ATAN_IDX_W = 6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_LAT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_LON    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 2'd3;

    // event codes
    localparam logic [1:0] EV_NONE       = 2'd0;
    localparam logic [1:0] EV_ACTIVATE   = 2'd1;
    localparam logic [1:0] EV_DEACTIVATE = 2'd2;

    // angles in 1e-7 degree
    localparam logic signed [UNITS_W-1:0] FULL_TURN    = 34'sd3600000000;
    localparam logic signed [UNITS_W-1:0] HALF_TURN    = 34'sd1800000000;
    localparam logic signed [UNITS_W-1:0] QUARTER_TURN = 34'sd900000000;

    // scales with 62 fraction bits; pi itself has 60
    localparam logic [DATA_W-1:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [DATA_W-1:0] RAD_PER_UNIT_Q62 =
        (PI_Q60 * 64'd4 + 64'd900000000) / 64'd1800000000;
    localparam logic [DATA_W-1:0] RAD_PER_METER_Q62 = 64'd723890739495;
    localparam logic [DATA_W-1:0] GAIN_Q62          = 64'd2800459870029452954;

    typedef logic [DATA_W-1:0] t_atan_tab [ATAN_LEN];

    typedef enum logic [3:0] {
        ST_IDLE, ST_WRAP, ST_FOLD, ST_MGO, ST_MWAIT,
        ST_ZRND, ST_CGO, ST_CWAIT, ST_DECIDE
    } t_state;

    typedef enum logic [1:0] {SRC_PLAT, SRC_ULAT, SRC_LON, SRC_RAD} t_src;
    typedef enum logic [1:0] {MOP_ANGLE, MOP_SPSU, MOP_CPCU, MOP_TCT} t_mop;

    typedef struct packed {
        logic cap_in;
        logic wrap;
        logic fold;
        logic mul_go;
        logic mul_store;
        logic zround;
        logic cord_go;
        logic cord_store;
        logic decide;
        t_src src;
        t_mop mop;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic cord_done;
        logic out_busy;
    } t_sts;

    // unsigned quotient by shift and subtract, table build only
    function automatic logic [DATA_W-1:0] udiv(input logic [DATA_W-1:0] num,
                                                input logic [DATA_W-1:0] den);
        logic [DATA_W-1:0] q;
        logic [DATA_W:0]   rem;
        q   = '0;
        rem = '0;
        for (int b = DATA_W - 1; b >= 0; b--) begin
            rem = {rem[DATA_W-1:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) with 62 fraction bits, by its power series
    function automatic t_atan_tab atan_q62_table();
        t_atan_tab          tab;
        logic [DATA_W-1:0]  sum;
        logic [DATA_W-1:0]  term;
        logic [DATA_W-1:0]  dv;
        logic               minus;
        int                 n;
        tab[0] = PI_Q60;
        for (int i = 1; i < ATAN_LEN; i++) begin
            sum   = '0;
            dv    = 64'd1;
            minus = 1'b0;
            for (n = i; n <= 62; n += 2 * i) begin
                term  = udiv(64'd1 << (62 - n), dv);
                sum   = minus ? sum - term : sum + term;
                minus = ~minus;
                dv    = dv + 64'd2;
            end
            tab[i] = sum;
        end
        return tab;
    endfunction

endpackage

// ===== design/gpt_mul.sv =====
// Sequential 64x64 unsigned multiplier, one 32x32 partial product per cycle.
// Depends on gpt_pkg.
module gpt_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [gpt_pkg::DATA_W-1:0]  i_a,
    input  logic [gpt_pkg::DATA_W-1:0]  i_b,
    output logic [2*gpt_pkg::DATA_W-1:0] o_prod,
    output logic                        o_done
);
    import gpt_pkg::*;

    localparam int HW = DATA_W / 2;

    logic [DATA_W-1:0]   r_a, r_b;
    logic [2*DATA_W-1:0] r_acc;
    logic [DATA_W-1:0]   r_pp;
    logic [1:0]          r_sh;
    logic                r_pp_v;
    logic [2:0]          r_cnt;
    logic                r_busy, r_done;
    logic [HW-1:0]       op_a, op_b;
    logic [2*DATA_W-1:0] pp_ext;

    assign op_a   = r_cnt[1] ? r_a[DATA_W-1:HW] : r_a[HW-1:0];
    assign op_b   = r_cnt[0] ? r_b[DATA_W-1:HW] : r_b[HW-1:0];
    assign pp_ext = {{DATA_W{1'b0}}, r_pp} << (HW * r_sh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_pp_v <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
                r_cnt  <= '0;
                r_pp_v <= 1'b0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_pp   <= op_a * op_b;
                r_sh   <= 2'(r_cnt[1]) + 2'(r_cnt[0]);
                r_pp_v <= (r_cnt != 3'd4);
                if (r_pp_v) begin
                    r_acc <= r_acc + pp_ext;
                end
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_prod = r_acc;
    assign o_done = r_done;
endmodule

// ===== design/gpt_cordic.sv =====
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Depends on gpt_pkg for the arctangent table and gain.
module gpt_cordic #(
    parameter int FRACTION_BITS = 48,
    parameter int CORDIC_STEPS  = 48
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [gpt_pkg::DATA_W-1:0] i_z,
    output logic signed [gpt_pkg::DATA_W-1:0] o_cos,
    output logic signed [gpt_pkg::DATA_W-1:0] o_sin,
    output logic                              o_done
);
    import gpt_pkg::*;

    localparam int STEP_W = $clog2(CORDIC_STEPS);
    localparam int DOWN   = 62 - FRACTION_BITS;
    localparam logic [DATA_W-1:0] RND = 64'd1 << (DOWN - 1);
    localparam logic [DATA_W-1:0] X0  = (GAIN_Q62 + RND) >> DOWN;
    localparam t_atan_tab ATAN_Q62 = atan_q62_table();

    logic signed [DATA_W-1:0] r_x, r_y, r_z;
    logic [STEP_W-1:0]        r_step;
    logic                     r_busy, r_done;
    logic signed [DATA_W-1:0] dx, dy, ang;

    assign dx  = r_y >>> r_step;
    assign dy  = r_x >>> r_step;
    assign ang = $signed((ATAN_Q62[ATAN_IDX_W'(r_step)] + RND) >> DOWN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= $signed(X0);
                r_y    <= '0;
                r_z    <= i_z;
                r_step <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!r_z[DATA_W-1]) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - ang;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + ang;
                end
                if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

    assign o_cos  = r_x;
    assign o_sin  = r_y;
    assign o_done = r_done;
endmodule

// ===== design/gpt_dp.sv =====
// Datapath: config registers, angle reduction, shared multiplier and CORDIC,
// product terms, range decision, trigger flags and the output register.
// Depends on gpt_pkg, gpt_mul and gpt_cordic.
module gpt_dp #(
    parameter int FRACTION_BITS = 48,
    parameter int CORDIC_STEPS  = 48
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  gpt_pkg::t_cmd                       i_cmd,
    output gpt_pkg::t_sts                       o_sts,
    input  logic                                i_cfg_we,
    input  logic [gpt_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [gpt_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic signed [gpt_pkg::LAT_W-1:0]    i_user_latitude,
    input  logic signed [gpt_pkg::LON_W-1:0]    i_user_longitude,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [1:0]                          o_event_kind,
    output logic                                o_in_range,
    output logic                                o_click_enabled
);
    import gpt_pkg::*;

    localparam logic [2*DATA_W-1:0] MQ_RND = 128'd1 << (FRACTION_BITS - 1);
    localparam logic [DATA_W-1:0]   Z_RND  = 64'd1 << (61 - FRACTION_BITS);

    // configuration and trigger state
    logic                     r_mode;
    logic signed [LAT_W-1:0]  r_plat;
    logic signed [LON_W-1:0]  r_plon;
    logic [RADIUS_W-1:0]      r_radius;
    logic                     r_outside, r_click;

    // per-fix working registers
    logic signed [LAT_W-1:0]   r_ulat;
    logic signed [LON_W-1:0]   r_ulon;
    logic signed [UNITS_W-1:0] r_units;
    logic [MAG_W-1:0]          r_mag;
    logic                      r_neg, r_flip, r_mneg;
    logic signed [DATA_W-1:0]  r_z;
    logic signed [DATA_W-1:0]  r_cp, r_sp, r_cu, r_su, r_ct, r_cr;
    logic signed [DATA_W-1:0]  r_ss, r_cc, r_tc;

    // output register
    logic       r_ovalid;
    logic [1:0] r_ev;
    logic       r_inr, r_oclk;

    logic signed [UNITS_W-1:0] units_src, units_wr, units_fd;
    logic                      fd_flip;
    logic [DATA_W-1:0]         mul_a, mul_b;
    logic                      mul_neg;
    logic [2*DATA_W-1:0]       prod;
    logic                      mul_done, cord_done;
    logic [2*DATA_W-1:0]       mq_sum;
    logic signed [DATA_W-1:0]  mq_mag, mq;
    logic [DATA_W-1:0]         zu;
    logic signed [DATA_W-1:0]  c_cos, c_sin, st_cos, st_sin;
    logic                      near_pt;
    logic [1:0]                n_ev;
    logic                      n_outside, n_click;

    function automatic logic [DATA_W-1:0] mag64(input logic signed [DATA_W-1:0] v);
        return v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
    endfunction

    // angle source and wrap into half turns
    always_comb begin
        unique case (i_cmd.src)
            SRC_PLAT: units_src = UNITS_W'(r_plat);
            SRC_ULAT: units_src = UNITS_W'(r_ulat);
            SRC_LON:  units_src = UNITS_W'(r_plon) - UNITS_W'(r_ulon);
            SRC_RAD:  units_src = '0;
        endcase
        if (units_src > HALF_TURN) begin
            units_wr = units_src - FULL_TURN;
        end else if (units_src < -HALF_TURN) begin
            units_wr = units_src + FULL_TURN;
        end else begin
            units_wr = units_src;
        end
    end

    // fold into the CORDIC's quarter-turn range
    always_comb begin
        fd_flip = 1'b1;
        if (r_units > QUARTER_TURN) begin
            units_fd = r_units - HALF_TURN;
        end else if (r_units < -QUARTER_TURN) begin
            units_fd = r_units + HALF_TURN;
        end else begin
            units_fd = r_units;
            fd_flip  = 1'b0;
        end
    end

    // multiplier operands
    always_comb begin
        unique case (i_cmd.mop)
            MOP_ANGLE: begin
                mul_a   = DATA_W'(r_mag);
                mul_b   = (i_cmd.src == SRC_RAD) ? RAD_PER_METER_Q62 : RAD_PER_UNIT_Q62;
                mul_neg = 1'b0;
            end
            MOP_SPSU: begin
                mul_a   = mag64(r_sp);
                mul_b   = mag64(r_su);
                mul_neg = r_sp[DATA_W-1] ^ r_su[DATA_W-1];
            end
            MOP_CPCU: begin
                mul_a   = mag64(r_cp);
                mul_b   = mag64(r_cu);
                mul_neg = r_cp[DATA_W-1] ^ r_cu[DATA_W-1];
            end
            MOP_TCT: begin
                mul_a   = mag64(r_cc);
                mul_b   = mag64(r_ct);
                mul_neg = r_cc[DATA_W-1] ^ r_ct[DATA_W-1];
            end
        endcase
    end

    gpt_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_go),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_prod  (prod),
        .o_done  (mul_done)
    );

    gpt_cordic #(
        .FRACTION_BITS (FRACTION_BITS),
        .CORDIC_STEPS  (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.cord_go),
        .i_z     (r_z),
        .o_cos   (c_cos),
        .o_sin   (c_sin),
        .o_done  (cord_done)
    );

    // rounded fixed-point product, half away from zero
    assign mq_sum = prod + MQ_RND;
    assign mq_mag = $signed(mq_sum[FRACTION_BITS +: DATA_W]);
    assign mq     = r_mneg ? -mq_mag : mq_mag;

    // radians from scaled magnitude
    assign zu = (prod[DATA_W-1:0] + Z_RND) >> (62 - FRACTION_BITS);

    assign st_cos  = r_flip ? -c_cos : c_cos;
    assign st_sin  = r_flip ? -c_sin : c_sin;
    assign near_pt = (r_ss + r_tc) >= r_cr;

    // trigger / click flag update for the decision
    always_comb begin
        n_ev      = EV_NONE;
        n_outside = r_outside;
        n_click   = r_click;
        if (!r_mode) begin
            if (near_pt && r_outside) begin
                n_ev      = EV_ACTIVATE;
                n_outside = 1'b0;
            end else if (!near_pt && !r_outside) begin
                n_ev      = EV_DEACTIVATE;
                n_outside = 1'b1;
            end
        end else begin
            n_click = near_pt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= 1'b0;
            r_plat    <= '0;
            r_plon    <= '0;
            r_radius  <= RADIUS_W'(20);
            r_outside <= 1'b0;
            r_click   <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TRIGGER_MODE: r_mode   <= i_cfg_data[0];
                    CFG_POINT_LAT:    r_plat   <= i_cfg_data[LAT_W-1:0];
                    CFG_POINT_LON:    r_plon   <= i_cfg_data[LON_W-1:0];
                    CFG_RADIUS:       r_radius <= i_cfg_data[RADIUS_W-1:0];
                endcase
            end
            if (i_cmd.decide) begin
                r_ovalid  <= 1'b1;
                r_inr     <= near_pt;
                r_ev      <= n_ev;
                r_outside <= n_outside;
                r_click   <= n_click;
                r_oclk    <= n_click;
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_ulat <= i_user_latitude;
            r_ulon <= i_user_longitude;
        end
        if (i_cmd.wrap) begin
            r_units <= units_wr;
        end
        if (i_cmd.fold) begin
            if (i_cmd.src == SRC_RAD) begin
                r_mag  <= MAG_W'(r_radius);
                r_neg  <= 1'b0;
                r_flip <= 1'b0;
            end else begin
                r_mag  <= units_fd[UNITS_W-1] ? MAG_W'(-units_fd) : MAG_W'(units_fd);
                r_neg  <= units_fd[UNITS_W-1];
                r_flip <= fd_flip;
            end
        end
        if (i_cmd.mul_go) begin
            r_mneg <= mul_neg;
        end
        if (i_cmd.mul_store) begin
            unique case (i_cmd.mop)
                MOP_SPSU:  r_ss <= mq;
                MOP_CPCU:  r_cc <= mq;
                MOP_TCT:   r_tc <= mq;
                MOP_ANGLE: ;
            endcase
        end
        if (i_cmd.zround) begin
            r_z <= r_neg ? -$signed(zu) : $signed(zu);
        end
        if (i_cmd.cord_store) begin
            unique case (i_cmd.src)
                SRC_PLAT: begin
                    r_cp <= st_cos;
                    r_sp <= st_sin;
                end
                SRC_ULAT: begin
                    r_cu <= st_cos;
                    r_su <= st_sin;
                end
                SRC_LON:  r_ct <= st_cos;
                SRC_RAD:  r_cr <= st_cos;
            endcase
        end
    end

    assign o_sts.mul_done  = mul_done;
    assign o_sts.cord_done = cord_done;
    assign o_sts.out_busy  = r_ovalid && !i_out_ready;

    assign o_out_valid     = r_ovalid;
    assign o_event_kind    = r_ev;
    assign o_in_range      = r_inr;
    assign o_click_enabled = r_oclk;
endmodule

// ===== design/gpt_ctrl.sv =====
// Controller: sequences angle reduction, multiplies and CORDIC runs per fix.
// Depends on gpt_pkg.
module gpt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  gpt_pkg::t_sts i_sts,
    output gpt_pkg::t_cmd o_cmd
);
    import gpt_pkg::*;

    t_state r_state, n_state;
    t_src   r_src, n_src;
    t_mop   r_mop, n_mop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_src   <= SRC_PLAT;
            r_mop   <= MOP_ANGLE;
        end else begin
            r_state <= n_state;
            r_src   <= n_src;
            r_mop   <= n_mop;
        end
    end

    always_comb begin
        n_state = r_state;
        n_src   = r_src;
        n_mop   = r_mop;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_WRAP;
                    n_src   = SRC_PLAT;
                end
            end
            ST_WRAP: n_state = ST_FOLD;
            ST_FOLD: begin
                n_state = ST_MGO;
                n_mop   = MOP_ANGLE;
            end
            ST_MGO:  n_state = ST_MWAIT;
            ST_MWAIT: begin
                if (i_sts.mul_done) begin
                    unique case (r_mop)
                        MOP_ANGLE: n_state = ST_ZRND;
                        MOP_SPSU: begin
                            n_mop   = MOP_CPCU;
                            n_state = ST_MGO;
                        end
                        MOP_CPCU: begin
                            n_mop   = MOP_TCT;
                            n_state = ST_MGO;
                        end
                        MOP_TCT:  n_state = ST_DECIDE;
                    endcase
                end
            end
            ST_ZRND: n_state = ST_CGO;
            ST_CGO:  n_state = ST_CWAIT;
            ST_CWAIT: begin
                if (i_sts.cord_done) begin
                    if (r_src == SRC_RAD) begin
                        n_mop   = MOP_SPSU;
                        n_state = ST_MGO;
                    end else begin
                        n_src   = t_src'(2'(r_src) + 2'd1);
                        n_state = ST_WRAP;
                    end
                end
            end
            ST_DECIDE: begin
                if (!i_sts.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready          = (r_state == ST_IDLE);
        o_cmd.cap_in     = (r_state == ST_IDLE) && i_valid;
        o_cmd.wrap       = (r_state == ST_WRAP);
        o_cmd.fold       = (r_state == ST_FOLD);
        o_cmd.mul_go     = (r_state == ST_MGO);
        o_cmd.mul_store  = (r_state == ST_MWAIT) && i_sts.mul_done;
        o_cmd.zround     = (r_state == ST_ZRND);
        o_cmd.cord_go    = (r_state == ST_CGO);
        o_cmd.cord_store = (r_state == ST_CWAIT) && i_sts.cord_done;
        o_cmd.decide     = (r_state == ST_DECIDE) && !i_sts.out_busy;
        o_cmd.src        = r_src;
        o_cmd.mop        = r_mop;
    end
endmodule

// ===== design/geofence_proximity_trigger.sv =====
// Top level of the geofence proximity trigger: controller plus datapath.
// Depends on gpt_pkg, gpt_ctrl and gpt_dp.
//
// Channel   | Direction | Transaction contents
// ----------+-----------+------------------------------------------------------
// s (fix)   | in        | tdata: user_latitude[30:0], user_longitude[62:31]
// m (result)| out       | tdata: in_range[0], click_enabled[1]; tuser: event_kind
// cfg       | in        | write enable, register index, write data
//
// Sequence: four angle passes (point latitude, user latitude, longitude
// difference, radius), each a wrap, a fold, a multiply, z rounding and a run of
// the shared CORDIC; then three products and a decision. The shared CORDIC and
// multiplier serve one fix at a time: the next fix is accepted only after the
// decision for the previous one has been made.
// Reset (synchronous, active low) restores the config registers and clears
// the trigger and click flags. A stalled result sits in the output register
// while the next fix is accepted; the block holds before its decision until
// that register is free.
module geofence_proximity_trigger #(
    parameter int FRACTION_BITS = 48,
    parameter int CORDIC_STEPS  = 48
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // fix input
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [63:0]                        i_s_tdata,   // user_latitude, user_longitude
    // result output
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [7:0]                         o_m_tdata,   // in_range, click_enabled
    output logic [1:0]                         o_m_tuser,   // event_kind
    // configuration writes
    input  logic                               i_cfg_we,
    input  logic [gpt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [gpt_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import gpt_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_range, click_enabled;

    gpt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    gpt_dp #(
        .FRACTION_BITS (FRACTION_BITS),
        .CORDIC_STEPS  (CORDIC_STEPS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_user_latitude  (i_s_tdata[LAT_W-1:0]),
        .i_user_longitude (i_s_tdata[LAT_W+LON_W-1:LAT_W]),
        .i_out_ready      (i_m_tready),
        .o_out_valid      (o_m_tvalid),
        .o_event_kind     (o_m_tuser),
        .o_in_range       (in_range),
        .o_click_enabled  (click_enabled)
    );

    assign o_m_tdata = {6'd0, click_enabled, in_range};
endmodule

// ===== tb/tb_geofence_proximity_trigger.sv =====
// Testbench for geofence_proximity_trigger: drives position fixes over the stream input,
// predicts each result with a CORDIC great-circle model and checks the stream output.
// Depends on gpt_pkg (register indexes, event codes) and the design under test.
`timescale 1ns / 1ps

module tb_geofence_proximity_trigger;
    import gpt_pkg::*;

    localparam int FB        = 48;
    localparam int STEPS     = 48;
    localparam int TAB_LEN   = 60;
    localparam int WD_LIMIT  = 20000;   // cycles with no transaction on any port
    localparam int LONG_HOLD = 3000;    // receiver hold-off, forces a stalled input
    localparam int TAIL      = 400;     // slack after draining, longer than one fix's latency

    localparam logic [63:0] PI60       = 64'h3243F6A8885A308D;
    localparam logic [63:0] DEG_TO_RAD = (PI60 * 64'd4 + 64'd900000000) / 64'd1800000000;
    localparam logic [63:0] M_TO_RAD   = 64'd723890739495;
    localparam logic [63:0] K_GAIN     = 64'd2800459870029452954;
    localparam longint      TURN       = 64'sd3600000000;
    localparam longint      HALF       = 64'sd1800000000;
    localparam longint      QUARTER    = 64'sd900000000;

    typedef struct {
        logic [30:0] lat;
        logic [31:0] lon;
    } fix_t;

    typedef struct {
        logic [1:0] ev;
        logic       near;
        logic       click;
    } verdict_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    geofence_proximity_trigger dut (.*);

    always #6 i_clk = ~i_clk;

    // shadow of the configuration and of the trigger state
    logic        sh_mode = 1'b0;
    logic [30:0] sh_plat = '0;
    logic [31:0] sh_plon = '0;
    logic [15:0] sh_radius = 16'd20;
    logic        sh_outside = 1'b0;
    logic        sh_click = 1'b0;

    logic [63:0] atan_tab [TAB_LEN];

    fix_t     pending_fixes [$];
    verdict_t expected_verdicts [$];

    int  errors = 0;
    int  fixes_sent = 0;
    int  verdicts_seen = 0;
    int  entries = 0;
    int  exits = 0;
    int  hits = 0;
    bit  idling = 1'b1;
    bit  hold_req = 1'b0;
    bit  fix_taken = 1'b0;

    task automatic report(input string what);
        $display("mismatch @%0t: %s", $realtime, what);
        errors++;
    endtask

    function automatic logic [63:0] rnd62(input logic [63:0] v);
        return (v + 64'd8192) >> 14;
    endfunction

    function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic          neg;
        logic [63:0]   ua, ub, r;
        logic [127:0]  p;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? -a : a;
        ub  = (b < 0) ? -b : b;
        p   = ua * ub;
        p   = p + (128'd1 << (FB - 1));
        r   = p[FB+63:FB];
        return neg ? -r : r;
    endfunction

    // rotation-mode CORDIC, z in radians with FB fraction bits
    task automatic rotate(input logic signed [63:0] z0,
                          output logic signed [63:0] cs, output logic signed [63:0] sn);
        logic signed [63:0] x, y, z, dx, dy, a;
        x = rnd62(K_GAIN);
        y = 0;
        z = z0;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            a  = rnd62(atan_tab[i]);
            if (z >= 0) begin
                x -= dx; y += dy; z -= a;
            end else begin
                x += dx; y -= dy; z += a;
            end
        end
        cs = x;
        sn = y;
    endtask

    // sine and cosine of any angle in 1e-7 degree units
    task automatic trig_units(input longint units,
                              output logic signed [63:0] cs, output logic signed [63:0] sn);
        longint             r;
        logic               flip, neg;
        logic [63:0]        mag;
        logic signed [63:0] z;
        flip = 1'b0;
        r = units % TURN;
        if (r > HALF) r -= TURN;
        if (r < -HALF) r += TURN;
        if (r > QUARTER) begin
            r -= HALF; flip = 1'b1;
        end else if (r < -QUARTER) begin
            r += HALF; flip = 1'b1;
        end
        neg = r < 0;
        mag = neg ? -r : r;
        z = rnd62(mag * DEG_TO_RAD);
        rotate(neg ? -z : z, cs, sn);
        if (flip) begin
            cs = -cs; sn = -sn;
        end
    endtask

    // proximity decision plus trigger/click state update
    task automatic judge_fix(input fix_t f, output verdict_t v);
        logic signed [63:0] cp, sp, cu, su, ct, st, cr, sr, cosang;
        logic               near_pt;
        trig_units(longint'($signed(sh_plat)), cp, sp);
        trig_units(longint'($signed(f.lat)), cu, su);
        trig_units(longint'($signed(sh_plon)) - longint'($signed(f.lon)), ct, st);
        cosang = qmul(sp, su) + qmul(qmul(cp, cu), ct);
        rotate(rnd62(64'(sh_radius) * M_TO_RAD), cr, sr);
        near_pt = cosang >= cr;
        v.ev = EV_NONE;
        if (!sh_mode) begin
            if (near_pt && sh_outside) begin
                v.ev = EV_ACTIVATE; sh_outside = 1'b0;
            end else if (!near_pt && !sh_outside) begin
                v.ev = EV_DEACTIVATE; sh_outside = 1'b1;
            end
        end else begin
            sh_click = near_pt;
        end
        v.near  = near_pt;
        v.click = sh_click;
    endtask

    // input monitor: predict on every accepted fix
    always @(posedge i_clk) begin
        fix_t     f;
        verdict_t v;
        fix_taken <= i_s_tvalid && o_s_tready;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            f.lat = i_s_tdata[30:0];
            f.lon = i_s_tdata[62:31];
            judge_fix(f, v);
            expected_verdicts.insert(expected_verdicts.size(), v);
            fixes_sent++;
        end
    end

    // fix driver, changes on the falling edge
    int gap_left = 0;
    always @(negedge i_clk) begin
        fix_t f;
        if (i_rst_n) begin
            if (i_s_tvalid && !fix_taken) begin
                // hold the offered fix
            end else if (gap_left > 0) begin
                gap_left--;
                i_s_tvalid <= 1'b0;
            end else if (pending_fixes.size() > 0) begin
                f = pending_fixes.pop_front();
                i_s_tdata  <= {1'b0, f.lon, f.lat};
                i_s_tvalid <= 1'b1;
                if (idling && $urandom_range(0, 3) == 0)
                    gap_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 300)
                                                            : $urandom_range(1, 4);
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver backpressure, with one long hold-off on request
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            stall_left = LONG_HOLD;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else if (idling && $urandom_range(0, 3) == 0) begin
            stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 400)
                                                      : $urandom_range(1, 4);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // result monitor and checker
    always @(posedge i_clk) begin
        verdict_t v;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            verdicts_seen++;
            if (expected_verdicts.size() == 0) begin
                report("result transaction with no fix pending");
            end else begin
                v = expected_verdicts.pop_front();
                if (o_m_tuser != v.ev)
                    report($sformatf("event_kind %0d, want %0d", o_m_tuser, v.ev));
                if (o_m_tdata[0] != v.near)
                    report($sformatf("in_range %0b, want %0b", o_m_tdata[0], v.near));
                if (o_m_tdata[1] != v.click)
                    report($sformatf("click_enabled %0b, want %0b", o_m_tdata[1], v.click));
                if (v.ev == EV_ACTIVATE) entries++;
                if (v.ev == EV_DEACTIVATE) exits++;
                if (v.near) hits++;
            end
        end
    end

    // watchdog on transaction activity
    int quiet = 0;
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we ||
            (pending_fixes.size() == 0 && expected_verdicts.size() == 0))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WD_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WD_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_TRIGGER_MODE: sh_mode = data[0];
            CFG_POINT_LAT:    sh_plat = data[30:0];
            CFG_POINT_LON:    sh_plon = data;
            CFG_RADIUS:       sh_radius = data[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_geofence(input logic mode, input longint plat, input longint plon,
                                input int radius);
        cfg_write(CFG_TRIGGER_MODE, 32'(mode));
        cfg_write(CFG_POINT_LAT, 32'(plat) & 32'h7FFF_FFFF);
        cfg_write(CFG_POINT_LON, 32'(plon));
        cfg_write(CFG_RADIUS, 32'(radius));
    endtask

    task automatic push_fix(input longint lat, input longint lon);
        fix_t f;
        f.lat = lat[30:0];
        f.lon = lon[31:0];
        pending_fixes.insert(pending_fixes.size(), f);
    endtask

    // wait until the block has drained, plus a fix worth of slack
    task automatic drain();
        wait (pending_fixes.size() == 0 && !i_s_tvalid && expected_verdicts.size() == 0);
        repeat (TAIL) @(negedge i_clk);
    endtask

    // mostly fixes around the point so that entries and exits occur,
    // plus fully random coordinates over the whole field width
    task automatic random_fixes(input int n);
        longint span, dlat, dlon;
        span = longint'(sh_radius) * 120 + 300;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) < 7) begin
                dlat = longint'($urandom_range(0, 32'(2 * span))) - span;
                dlon = longint'($urandom_range(0, 32'(2 * span))) - span;
                push_fix(longint'($signed(sh_plat)) + dlat,
                         longint'($signed(sh_plon)) + dlon);
            end else begin
                push_fix(longint'($urandom()), longint'($urandom()));
            end
        end
    endtask

    initial begin
        for (int i = 0; i < TAB_LEN; i++) begin
            logic [63:0] sum, term, dv;
            logic        minus;
            sum = '0; dv = 64'd1; minus = 1'b0;
            if (i == 0) begin
                sum = PI60;
            end else begin
                for (int n = i; n <= 62; n += 2 * i) begin
                    term  = (64'd1 << (62 - n)) / dv;
                    sum   = minus ? sum - term : sum + term;
                    minus = ~minus;
                    dv    = dv + 64'd2;
                end
            end
            atan_tab[i] = sum;
        end

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // directed: reset values (point 0/0, radius 20 m, trigger mode)
        push_fix(0, 0);                 // inside from reset: no event
        push_fix(1000000, 0);           // first exit deactivates
        push_fix(2000000, 5);           // still outside
        push_fix(0, 0);                 // re-entry activates
        push_fix(1797, 0);              // around the 20 m edge
        push_fix(1800, 0);
        push_fix(1803, 0);
        push_fix(0, -1800);
        push_fix(900000000, 1800000000);
        push_fix(-900000000, -1800000000);
        push_fix(32'h3FFF_FFFF, 32'h7FFF_FFFF);     // field extremes, wrapped angles
        push_fix(32'h4000_0000, 32'h8000_0000);
        push_fix(0, 32'h7FFF_FFFF);
        push_fix(0, 0);
        drain();

        // click mode, zero radius: coincident point still counts as in range
        set_geofence(1'b1, 0, 0, 0);
        push_fix(0, 0);
        push_fix(1, 0);
        push_fix(0, 0);
        push_fix(0, 1);
        drain();

        // extremes of the point and radius; the receiver stalls for a long stretch
        set_geofence(1'b0, 900000000, 1800000000, 65535);
        hold_req = 1'b1;
        random_fixes(250);
        drain();

        set_geofence(1'b1, -900000000, -1800000000, 65535);
        idling = 1'b0;
        random_fixes(250);
        drain();
        idling = 1'b1;

        for (int ph = 0; ph < 5; ph++) begin
            set_geofence(1'($urandom_range(0, 1)),
                         longint'($urandom_range(0, 1800000000)) - 900000000,
                         longint'($urandom_range(0, 32'd3600000000)) - 1800000000,
                         int'((ph == 0) ? 0 : $urandom_range(0, (ph < 3) ? 200 : 65535)));
            random_fixes(250);
            drain();
        end

        $display("covered %0d fixes, %0d results: %0d in range, %0d entries, %0d exits",
                 fixes_sent, verdicts_seen, hits, entries, exits);
        $display("both modes, radius 0..65535, point at poles and date line, long stall");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/gpt_pkg.sv
design/gpt_mul.sv
design/gpt_cordic.sv
design/gpt_dp.sv
design/gpt_ctrl.sv
design/geofence_proximity_trigger.sv
tb/tb_geofence_proximity_trigger.sv
